@@ rtl/mvn_pkg.sv @@
package mvn_pkg;

    // Default sizes
    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int COORD_BITS_DEF   = 16;
    localparam int MAX_FACES_DEF    = 255;

    // Fixed field and store widths
    localparam int IDX_W   = 12;
    localparam int FIELD_W = 16;
    localparam int SUM_W   = 24;
    localparam int COUNT_W = 8;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic signed [FIELD_W-1:0] coord_z;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          read_index;
        logic signed [FIELD_W-1:0] normal_x;
        logic signed [FIELD_W-1:0] normal_y;
        logic signed [FIELD_W-1:0] normal_z;
        logic                      no_faces;
    } out_item_t;

    // Status and result of the unit-vector engine
    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic                      ok;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
    } norm_res_t;

endpackage

@@ rtl/mesh_vertex_normal_engine.sv @@
// Vertex normal engine: face-average normals over a stored mesh.
//
// s_item (valid/ready) carries one command item; m_item (valid/ready)
// carries the answer to a read item. Load, add-triangle and clear items
// give no answer.
// Steps, per item:
//   load vertex: a direct write to the position memory.
//   add triangle: position reads of the corners, the cross product,
//     the shared unit-vector engine (halving of a large cross
//     product, 32 root steps, 3 x 16 divide steps), then a read and a
//     write of the accumulator memory for each corner.
//     A degenerate face skips root and divide.
//   read vertex: the stored sums go through the same engine; an empty or
//     out-of-range vertex answers without it.
//   clear: one accumulator entry per cycle.
// After reset the same clearing pass runs before s_ready rises.
// Positions are not cleared.
// A finished answer waits in the output register while m_ready is low;
// later items are still taken, and a further read stalls only when its
// answer is ready and the output register is still full.
module mesh_vertex_normal_engine #(
    parameter int VERTEX_COUNT = mvn_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = mvn_pkg::COORD_BITS_DEF,
    parameter int MAX_FACES    = mvn_pkg::MAX_FACES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mvn_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mvn_pkg::out_item_t m_item
);

    localparam int ADDR_W  = $clog2(VERTEX_COUNT);
    localparam int CW      = COORD_BITS;
    localparam int DW      = CW + 1;
    localparam int PW      = 2 * DW;
    localparam int CROSS_W = PW + 1;
    localparam int NORM_W  = (CROSS_W > mvn_pkg::SUM_W) ? CROSS_W : mvn_pkg::SUM_W;
    localparam int POS_W   = 3 * CW;
    localparam int SW      = mvn_pkg::SUM_W;
    localparam int NW      = mvn_pkg::COUNT_W;
    localparam int ACC_W   = 3 * SW + NW;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_TRI_RD  = 4'd2;
    localparam logic [3:0] S_CROSS   = 4'd3;
    localparam logic [3:0] S_NSTART  = 4'd4;
    localparam logic [3:0] S_NWAIT   = 4'd5;
    localparam logic [3:0] S_CORN_RD = 4'd6;
    localparam logic [3:0] S_CORN_WR = 4'd7;
    localparam logic [3:0] S_RD_ACC  = 4'd8;
    localparam logic [3:0] S_RSLT    = 4'd9;

    logic [3:0]        state_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [1:0]        ph_reg;
    logic              tri_reg;
    logic [ADDR_W-1:0] ca_reg, cb_reg, cc_reg;
    logic [POS_W-1:0]  pa_reg, pb_reg;
    logic signed [DW-1:0]      u0_reg, u1_reg, u2_reg, v0_reg, v1_reg, v2_reg;
    logic signed [PW-1:0]      p1_reg, p2_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    mvn_pkg::out_item_t rslt_reg, m_item_reg;
    logic              m_valid_reg;

    logic              s_fire, out_load;
    logic              pos_we;
    logic [ADDR_W-1:0] pos_waddr, pos_raddr;
    logic [POS_W-1:0]  pos_wdata, pos_rdata;
    logic              acc_we;
    logic [ADDR_W-1:0] acc_waddr, acc_raddr, corner_addr;
    logic [ACC_W-1:0]  acc_wdata, acc_rdata;
    logic signed [SW-1:0] rd_sx, rd_sy, rd_sz;
    logic [NW-1:0]     rd_cnt;
    logic              norm_start;
    logic signed [NORM_W-1:0] nin_x, nin_y, nin_z;
    mvn_pkg::norm_res_t norm_res;
    logic signed [CW-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, pc_x, pc_y, pc_z;
    logic signed [DW-1:0] op1a, op1b, op2a, op2b;
    logic              tri_ok, rd_ok;

    mvn_ram #(.WIDTH(POS_W), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    mvn_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_COUNT)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    mvn_norm #(.IN_W(NORM_W)) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .c_x     (nin_x),
        .c_y     (nin_y),
        .c_z     (nin_z),
        .res     (norm_res)
    );

    assign s_ready  = state_reg == S_IDLE;
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == S_RSLT) && (!m_valid_reg || m_ready);

    assign tri_ok = (32'(s_item.corner_a) < VERTEX_COUNT) &&
                    (32'(s_item.corner_b) < VERTEX_COUNT) &&
                    (32'(s_item.corner_c) < VERTEX_COUNT);
    assign rd_ok  = 32'(s_item.vertex_index) < VERTEX_COUNT;

    // Position memory: load writes, triangle reads corners in turn
    assign pos_we    = s_fire && (s_item.kind == mvn_pkg::KIND_LOAD) && rd_ok;
    assign pos_waddr = ADDR_W'(s_item.vertex_index);
    assign pos_wdata = {CW'($unsigned(s_item.coord_x)), CW'($unsigned(s_item.coord_y)),
                        CW'($unsigned(s_item.coord_z))};

    always_comb begin
        case (ph_reg)
            2'd0:    pos_raddr = ca_reg;
            2'd1:    pos_raddr = cb_reg;
            default: pos_raddr = cc_reg;
        endcase
        case (ph_reg)
            2'd0:    corner_addr = ca_reg;
            2'd1:    corner_addr = cb_reg;
            default: corner_addr = cc_reg;
        endcase
    end

    assign pa_x = pa_reg[3*CW-1:2*CW];
    assign pa_y = pa_reg[2*CW-1:CW];
    assign pa_z = pa_reg[CW-1:0];
    assign pb_x = pb_reg[3*CW-1:2*CW];
    assign pb_y = pb_reg[2*CW-1:CW];
    assign pb_z = pb_reg[CW-1:0];
    assign pc_x = pos_rdata[3*CW-1:2*CW];
    assign pc_y = pos_rdata[2*CW-1:CW];
    assign pc_z = pos_rdata[CW-1:0];

    // Cross product operands, one component per phase
    always_comb begin
        case (ph_reg)
            2'd0: begin
                op1a = u1_reg; op1b = v2_reg; op2a = u2_reg; op2b = v1_reg;
            end
            2'd1: begin
                op1a = u2_reg; op1b = v0_reg; op2a = u0_reg; op2b = v2_reg;
            end
            default: begin
                op1a = u0_reg; op1b = v1_reg; op2a = u1_reg; op2b = v0_reg;
            end
        endcase
    end

    // Accumulator memory fields
    assign rd_sx  = acc_rdata[ACC_W-1:2*SW+NW];
    assign rd_sy  = acc_rdata[2*SW+NW-1:SW+NW];
    assign rd_sz  = acc_rdata[SW+NW-1:NW];
    assign rd_cnt = acc_rdata[NW-1:0];

    assign acc_raddr = (state_reg == S_IDLE) ? ADDR_W'(s_item.vertex_index) : corner_addr;

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = corner_addr;
        acc_wdata = {rd_sx + SW'(norm_res.x), rd_sy + SW'(norm_res.y),
                     rd_sz + SW'(norm_res.z), rd_cnt + NW'(1)};
        case (state_reg)
            S_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = clr_reg;
                acc_wdata = '0;
            end
            S_CORN_WR: begin
                acc_we = rd_cnt < NW'(MAX_FACES);
            end
            default: acc_we = 1'b0;
        endcase
    end

    // Unit-vector engine input: stored sums for a read, else the face cross product
    assign norm_start = ((state_reg == S_RD_ACC) && (rd_cnt != '0)) ||
                        (state_reg == S_NSTART);
    assign nin_x = (state_reg == S_RD_ACC) ? NORM_W'(rd_sx) : NORM_W'(cx_reg);
    assign nin_y = (state_reg == S_RD_ACC) ? NORM_W'(rd_sy) : NORM_W'(cy_reg);
    assign nin_z = (state_reg == S_RD_ACC) ? NORM_W'(rd_sz) : NORM_W'(cz_reg);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ph_reg    <= 2'd0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    if (clr_reg == ADDR_W'(VERTEX_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                    clr_reg <= clr_reg + ADDR_W'(1);
                end
                S_IDLE: begin
                    if (s_fire) begin
                        rslt_reg.read_index <= s_item.vertex_index;
                        case (s_item.kind)
                            mvn_pkg::KIND_TRI: begin
                                if (tri_ok) begin
                                    ca_reg    <= ADDR_W'(s_item.corner_a);
                                    cb_reg    <= ADDR_W'(s_item.corner_b);
                                    cc_reg    <= ADDR_W'(s_item.corner_c);
                                    ph_reg    <= 2'd0;
                                    state_reg <= S_TRI_RD;
                                end
                            end
                            mvn_pkg::KIND_CLEAR: begin
                                clr_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            mvn_pkg::KIND_READ: begin
                                if (rd_ok) begin
                                    state_reg <= S_RD_ACC;
                                end else begin
                                    rslt_reg.normal_x <= '0;
                                    rslt_reg.normal_y <= '0;
                                    rslt_reg.normal_z <= '0;
                                    rslt_reg.no_faces <= 1'b1;
                                    state_reg         <= S_RSLT;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                // corner reads: read data arrives in the cycle after its address
                S_TRI_RD: begin
                    case (ph_reg)
                        2'd1:    pa_reg <= pos_rdata;
                        2'd2:    pb_reg <= pos_rdata;
                        2'd3: begin
                            u0_reg <= DW'(pb_x) - DW'(pa_x);
                            u1_reg <= DW'(pb_y) - DW'(pa_y);
                            u2_reg <= DW'(pb_z) - DW'(pa_z);
                            v0_reg <= DW'(pc_x) - DW'(pb_x);
                            v1_reg <= DW'(pc_y) - DW'(pb_y);
                            v2_reg <= DW'(pc_z) - DW'(pb_z);
                        end
                        default: ;
                    endcase
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        state_reg <= S_CROSS;
                    end
                end
                // two products per cycle, their difference in the cycle after
                S_CROSS: begin
                    p1_reg <= op1a * op1b;
                    p2_reg <= op2a * op2b;
                    case (ph_reg)
                        2'd1:    cx_reg <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
                        2'd2:    cy_reg <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
                        2'd3:    cz_reg <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
                        default: ;
                    endcase
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        tri_reg   <= 1'b1;
                        state_reg <= S_NSTART;
                    end
                end
                S_NSTART: state_reg <= S_NWAIT;
                S_NWAIT: begin
                    if (norm_res.done) begin
                        if (tri_reg) begin
                            ph_reg    <= 2'd0;
                            state_reg <= S_CORN_RD;
                        end else begin
                            rslt_reg.normal_x <= norm_res.x;
                            rslt_reg.normal_y <= norm_res.y;
                            rslt_reg.normal_z <= norm_res.z;
                            rslt_reg.no_faces <= !norm_res.ok;
                            state_reg         <= S_RSLT;
                        end
                    end
                end
                // per-corner read then write; the next read follows the write
                S_CORN_RD: state_reg <= S_CORN_WR;
                S_CORN_WR: begin
                    if (ph_reg == 2'd2) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ph_reg    <= ph_reg + 2'd1;
                        state_reg <= S_CORN_RD;
                    end
                end
                S_RD_ACC: begin
                    if (rd_cnt == '0) begin
                        rslt_reg.normal_x <= '0;
                        rslt_reg.normal_y <= '0;
                        rslt_reg.normal_z <= '0;
                        rslt_reg.no_faces <= 1'b1;
                        state_reg         <= S_RSLT;
                    end else begin
                        tri_reg   <= 1'b0;
                        state_reg <= S_NWAIT;
                    end
                end
                S_RSLT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_item_reg <= rslt_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The engine is never restarted while it is still working
    assert property (@(posedge aclk) disable iff (!aresetn)
        norm_start |-> !norm_res.busy)
        else $error("unit-vector engine started while busy");

    // Corner updates never push a face count past the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_we && (state_reg == S_CORN_WR)) |-> (32'(acc_wdata[NW-1:0]) <= MAX_FACES))
        else $error("face count written beyond limit");

    // An answer flagged empty carries a zero normal
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.no_faces) |->
        ((m_item.normal_x == '0) && (m_item.normal_y == '0) && (m_item.normal_z == '0)))
        else $error("empty answer with nonzero normal");

endmodule

@@ rtl/mvn_ram.sv @@
module mvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mvn_norm.sv @@
module mvn_norm #(
    parameter int IN_W = 35
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [IN_W-1:0] c_x,
    input  logic signed [IN_W-1:0] c_y,
    input  logic signed [IN_W-1:0] c_z,
    output mvn_pkg::norm_res_t     res
);

    localparam int MAG_W = (IN_W > 32) ? IN_W : 32;
    localparam int DIV_W = 49;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_HALVE = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_CHK   = 3'd3;
    localparam logic [2:0] N_ROOT  = 3'd4;
    localparam logic [2:0] N_DINIT = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;

    logic [2:0]        state_reg;
    logic [MAG_W-1:0]  mag0_reg, mag1_reg, mag2_reg;
    logic [2:0]        neg_reg;
    logic [4:0]        cnt_reg;
    logic [1:0]        comp_reg;
    logic [61:0]       sq_reg;
    logic [63:0]       s2_reg, rem_reg, r_reg, bit_reg;
    logic [DIV_W-1:0]  drem_reg, dsh_reg;
    logic [15:0]       q_reg;
    logic              done_reg, ok_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    logic [30:0]       m_sq, m_div;
    logic [63:0]       root_try;
    logic              div_ge;
    logic [15:0]       q_next;
    logic signed [15:0] n_next;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [IN_W-1:0] c);
        logic [IN_W-1:0] u;
        u = c[IN_W-1] ? IN_W'(-c) : IN_W'(c);
        return MAG_W'(u);
    endfunction

    // Component selects for the squaring and dividing steps
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    m_sq = mag0_reg[30:0];
            2'd1:    m_sq = mag1_reg[30:0];
            default: m_sq = mag2_reg[30:0];
        endcase
        case (comp_reg)
            2'd0:    m_div = mag0_reg[30:0];
            2'd1:    m_div = mag1_reg[30:0];
            default: m_div = mag2_reg[30:0];
        endcase
    end

    assign root_try = r_reg + bit_reg;
    assign div_ge   = drem_reg >= dsh_reg;
    assign q_next   = {q_reg[14:0], div_ge};
    assign n_next   = neg_reg[comp_reg] ? -$signed(q_next) : $signed(q_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        mag0_reg  <= mag_of(c_x);
                        mag1_reg  <= mag_of(c_y);
                        mag2_reg  <= mag_of(c_z);
                        neg_reg   <= {c_z[IN_W-1], c_y[IN_W-1], c_x[IN_W-1]};
                        state_reg <= N_HALVE;
                    end
                end
                // halve all until the largest fits in 31 bits
                N_HALVE: begin
                    if ((|mag0_reg[MAG_W-1:31]) || (|mag1_reg[MAG_W-1:31]) ||
                        (|mag2_reg[MAG_W-1:31])) begin
                        mag0_reg <= mag0_reg >> 1;
                        mag1_reg <= mag1_reg >> 1;
                        mag2_reg <= mag2_reg >> 1;
                    end else begin
                        cnt_reg   <= 5'd0;
                        s2_reg    <= 64'd0;
                        state_reg <= N_SQ;
                    end
                end
                // one square per cycle, accumulated in the cycle after
                N_SQ: begin
                    if (cnt_reg != 5'd3) begin
                        sq_reg <= m_sq * m_sq;
                    end
                    if (cnt_reg != 5'd0) begin
                        s2_reg <= s2_reg + 64'(sq_reg);
                    end
                    if (cnt_reg == 5'd3) begin
                        state_reg <= N_CHK;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                N_CHK: begin
                    if (s2_reg == 64'd0) begin
                        nx_reg    <= '0;
                        ny_reg    <= '0;
                        nz_reg    <= '0;
                        ok_reg    <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end else begin
                        rem_reg   <= s2_reg;
                        r_reg     <= 64'd0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= 5'd0;
                        state_reg <= N_ROOT;
                    end
                end
                // integer square root, two bits of radicand per cycle
                N_ROOT: begin
                    if (rem_reg >= root_try) begin
                        rem_reg <= rem_reg - root_try;
                        r_reg   <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        comp_reg  <= 2'd0;
                        state_reg <= N_DINIT;
                    end
                end
                // rounded quotient (m*2^15 + len) / (2*len)
                N_DINIT: begin
                    drem_reg  <= DIV_W'({m_div, 15'd0}) + DIV_W'(r_reg[32:0]);
                    dsh_reg   <= {r_reg[32:0], 16'd0};
                    q_reg     <= 16'd0;
                    cnt_reg   <= 5'd0;
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    if (div_ge) begin
                        drem_reg <= drem_reg - dsh_reg;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        case (comp_reg)
                            2'd0:    nx_reg <= n_next;
                            2'd1:    ny_reg <= n_next;
                            default: nz_reg <= n_next;
                        endcase
                        if (comp_reg == 2'd2) begin
                            ok_reg    <= 1'b1;
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end else begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_DINIT;
                        end
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign res.busy = state_reg != N_IDLE;
    assign res.done = done_reg;
    assign res.ok   = ok_reg;
    assign res.x    = nx_reg;
    assign res.y    = ny_reg;
    assign res.z    = nz_reg;

endmodule
